[hdl/kst_pkg.sv]
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants for the spanning tree block
// Field widths, the front-to-back request struct and the tree state codes.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int unsigned VertW    = 6;
  localparam int unsigned NvW      = 7;
  localparam int unsigned WeightW  = 16;
  localparam int unsigned TotalW   = 22;
  localparam int unsigned MaxVerts = 64;
  // stored edge: {from, to, weight}
  localparam int unsigned EdgeW    = 2 * VertW + WeightW;

  // Loaded edge as handed from the front part to the back part
  typedef struct packed {
    logic [VertW-1:0]   from_v;
    logic [VertW-1:0]   to_v;
    logic [WeightW-1:0] weight;
    logic               last;
    logic               bad;
  } edge_req_t;

  // Tree engine states
  typedef enum logic [11:0] {
    StClear   = 12'b0000_0000_0001,
    StIdle    = 12'b0000_0000_0010,
    StSortRd  = 12'b0000_0000_0100,
    StSortLd  = 12'b0000_0000_1000,
    StSortCmp = 12'b0000_0001_0000,
    StSortWb  = 12'b0000_0010_0000,
    StBldRd   = 12'b0000_0100_0000,
    StBldEd   = 12'b0000_1000_0000,
    StBldRa   = 12'b0001_0000_0000,
    StBldRb   = 12'b0010_0000_0000,
    StEmitRd  = 12'b0100_0000_0000,
    StEmit    = 12'b1000_0000_0000
  } state_e;

endpackage

[hdl/kst_if.sv]
// ----------------------------------------------------------------------------
// kst_in_if / kst_out_if: valid/ready channels of the spanning tree block
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface kst_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  edge_from;
  logic [5:0]  edge_to;
  logic [15:0] edge_weight;
  logic        last_edge;
  modport source (output valid, edge_from, edge_to, edge_weight, last_edge, input ready);
  modport sink   (input valid, edge_from, edge_to, edge_weight, last_edge, output ready);
endinterface

interface kst_out_if;
  logic        valid;
  logic        ready;
  logic        tree_valid;
  logic [5:0]  tree_from;
  logic [5:0]  tree_to;
  logic [15:0] tree_weight;
  logic [21:0] total_weight;
  logic        spanning;
  logic        dropped;
  logic        last_result;
  modport source (output valid, tree_valid, tree_from, tree_to, tree_weight, total_weight,
                  spanning, dropped, last_result, input ready);
  modport sink   (input valid, tree_valid, tree_from, tree_to, tree_weight, total_weight,
                  spanning, dropped, last_result, output ready);
endinterface

[hdl/kst_ram.sv]
// ----------------------------------------------------------------------------
// kst_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hdl/kst_fifo.sv]
// ----------------------------------------------------------------------------
// kst_fifo: short request queue between front and back parts
// Two entries of edge requests, valid/ready on both sides.
// ----------------------------------------------------------------------------
module kst_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kst_pkg::edge_req_t  push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output kst_pkg::edge_req_t  pop_data_o,
  output logic                empty_o
);
  kst_pkg::edge_req_t buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q[1];
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= push_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

[hdl/kst_front.sv]
// ----------------------------------------------------------------------------
// kst_front: edge intake and range check
// Takes input requests, flags edges with bad endpoints, queues them all.
// ----------------------------------------------------------------------------
module kst_front (
  kst_in_if.sink                   in_if,
  input  logic [kst_pkg::NvW-1:0]  nv_i,
  input  logic                     full_i,
  output logic                     push_o,
  output kst_pkg::edge_req_t       push_data_o
);
  logic ep_ok;

  // endpoints must lie below the vertex count at intake
  assign ep_ok = ({1'b0, in_if.edge_from} < nv_i) && ({1'b0, in_if.edge_to} < nv_i);
  assign in_if.ready = ~full_i;

  // a bad edge still travels, with its flag, so a run end is never lost
  assign push_o      = in_if.valid & ~full_i;
  assign push_data_o = '{from_v: in_if.edge_from,
                         to_v:   in_if.edge_to,
                         weight: in_if.edge_weight,
                         last:   in_if.last_edge,
                         bad:    ~ep_ok};
endmodule

[hdl/kst_back.sv]
// ----------------------------------------------------------------------------
// kst_back: edge store, exchange sort, union-find and result emission
// Sequencer over three RAMs: edge store, parent table and kept-edge store.
// ----------------------------------------------------------------------------
module kst_back #(
  parameter int unsigned MaxEdges = 256,
  parameter int unsigned WBits    = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [kst_pkg::NvW-1:0]  nv_i,
  input  logic                     empty_i,
  input  kst_pkg::edge_req_t       req_i,
  output logic                     pop_o,
  kst_out_if.source                out_if
);
  localparam int unsigned AW = $clog2(MaxEdges);
  localparam int unsigned CW = $clog2(MaxEdges + 1);
  localparam int unsigned EW = kst_pkg::EdgeW;
  localparam int unsigned VW = kst_pkg::VertW;
  localparam int unsigned NW = kst_pkg::NvW;
  localparam int unsigned TW = kst_pkg::TotalW;
  localparam logic [15:0] WMask = (WBits >= 16) ? 16'hFFFF :
                                  16'((32'd1 << WBits) - 32'd1);

  kst_pkg::state_e st_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] i_q, j_q;
  logic [EW-1:0] ei_q, ej_q;
  logic [VW-1:0] ra_q, wk_q, clr_q;
  logic [VW-1:0] tcnt_q, ocnt_q;
  logic [TW-1:0] sum_q;
  logic          drop_q;
  logic          e_we, p_we, t_we;
  logic [AW-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_rdata, t_rdata;
  logic [VW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  logic [NW-1:0] nv, limit;
  logic [VW-1:0] rd_from, rd_to, ej_to;
  logic [VW:0]   onext;
  logic          in_ok, swap, in_end, jn_end, rd_bad, root_hit, keep_ok;
  logic          has_tree, last_res;

  assign nv    = (nv_i > NW'(kst_pkg::MaxVerts)) ? NW'(kst_pkg::MaxVerts) : nv_i;
  assign limit = (nv == '0) ? '0 : nv - NW'(1);

  kst_ram #(.Width(EW), .Depth(MaxEdges)) u_edge_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );
  kst_ram #(.Width(VW), .Depth(kst_pkg::MaxVerts)) u_parent_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );
  kst_ram #(.Width(EW), .Depth(kst_pkg::MaxVerts)) u_tree_ram (
    .clk_i, .we_i(t_we), .waddr_i(tcnt_q), .wdata_i(ej_q),
    .raddr_i(ocnt_q), .rdata_o(t_rdata)
  );

  // decode of stored words and loop ends
  assign rd_from  = e_rdata[EW-1 -: VW];
  assign rd_to    = e_rdata[EW-1-VW -: VW];
  assign ej_to    = ej_q[EW-1-VW -: VW];
  assign in_ok    = ~req_i.bad & (cnt_q < CW'(MaxEdges));
  assign swap     = (ei_q[15:0] > e_rdata[15:0]);
  assign in_end   = (CW'(i_q) + CW'(1)) >= cnt_q;
  assign jn_end   = (CW'(j_q) + CW'(1)) >= cnt_q;
  assign rd_bad   = ({1'b0, rd_from} >= nv) || ({1'b0, rd_to} >= nv);
  assign root_hit = (p_rdata == wk_q);
  assign keep_ok  = ({1'b0, tcnt_q} < limit);
  assign onext    = {1'b0, ocnt_q} + {{VW{1'b0}}, 1'b1};
  assign last_res = (onext >= {1'b0, tcnt_q});
  assign has_tree = (tcnt_q != '0);

  assign pop_o = (st_q == kst_pkg::StIdle) & ~empty_i;

  // RAM port control
  always_comb begin
    e_we    = 1'b0;
    e_waddr = cnt_q[AW-1:0];
    e_wdata = {req_i.from_v, req_i.to_v, req_i.weight & WMask};
    e_raddr = i_q;
    p_we    = 1'b0;
    p_waddr = clr_q;
    p_wdata = clr_q;
    p_raddr = wk_q;
    t_we    = 1'b0;
    unique case (st_q)
      kst_pkg::StClear:  p_we = 1'b1;
      kst_pkg::StIdle:   e_we = pop_o & in_ok;
      kst_pkg::StSortRd: e_raddr = i_q;
      kst_pkg::StSortLd: e_raddr = j_q;
      kst_pkg::StSortCmp: begin
        // the larger entry moves to j, the smaller stays in ei_q
        e_we    = swap;
        e_waddr = j_q;
        e_wdata = ei_q;
        e_raddr = j_q + AW'(1);
      end
      kst_pkg::StSortWb: begin
        e_we    = 1'b1;
        e_waddr = i_q;
        e_wdata = ei_q;
      end
      kst_pkg::StBldRd: e_raddr = i_q;
      kst_pkg::StBldEd: p_raddr = rd_from;
      kst_pkg::StBldRa: p_raddr = root_hit ? ej_to : p_rdata;
      kst_pkg::StBldRb: begin
        p_raddr = p_rdata;
        if (root_hit && (wk_q != ra_q)) begin
          p_we    = 1'b1;
          p_waddr = wk_q;
          p_wdata = ra_q;
          t_we    = keep_ok;
        end
      end
      kst_pkg::StEmitRd, kst_pkg::StEmit: ;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= kst_pkg::StClear;
      cnt_q  <= '0;
      i_q    <= '0;
      j_q    <= '0;
      ei_q   <= '0;
      ej_q   <= '0;
      ra_q   <= '0;
      wk_q   <= '0;
      clr_q  <= '0;
      tcnt_q <= '0;
      ocnt_q <= '0;
      sum_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      unique case (st_q)
        // parent table gets parent[v] = v, one entry per cycle
        kst_pkg::StClear: begin
          clr_q <= clr_q + VW'(1);
          if (clr_q == VW'(kst_pkg::MaxVerts - 1)) st_q <= kst_pkg::StIdle;
        end
        kst_pkg::StIdle: if (pop_o) begin
          if (in_ok) cnt_q <= cnt_q + CW'(1);
          else drop_q <= 1'b1;
          if (req_i.last) begin
            i_q  <= '0;
            st_q <= kst_pkg::StSortRd;
          end
        end
        kst_pkg::StSortRd: begin
          if (in_end) begin
            i_q  <= '0;
            st_q <= (cnt_q == '0) ? kst_pkg::StEmitRd : kst_pkg::StBldRd;
          end else begin
            j_q  <= i_q + AW'(1);
            st_q <= kst_pkg::StSortLd;
          end
        end
        kst_pkg::StSortLd: begin
          ei_q <= e_rdata;
          st_q <= kst_pkg::StSortCmp;
        end
        kst_pkg::StSortCmp: begin
          if (swap) ei_q <= e_rdata;
          if (jn_end) st_q <= kst_pkg::StSortWb;
          else j_q <= j_q + AW'(1);
        end
        kst_pkg::StSortWb: begin
          i_q  <= i_q + AW'(1);
          st_q <= kst_pkg::StSortRd;
        end
        kst_pkg::StBldRd: st_q <= kst_pkg::StBldEd;
        kst_pkg::StBldEd: begin
          ej_q <= e_rdata;
          wk_q <= rd_from;
          if (rd_bad) begin
            // count lowered since loading
            drop_q <= 1'b1;
            if (in_end) st_q <= kst_pkg::StEmitRd;
            else begin
              i_q  <= i_q + AW'(1);
              st_q <= kst_pkg::StBldRd;
            end
          end else st_q <= kst_pkg::StBldRa;
        end
        // walk to the root of the first endpoint
        kst_pkg::StBldRa: begin
          if (root_hit) begin
            ra_q <= wk_q;
            wk_q <= ej_to;
            st_q <= kst_pkg::StBldRb;
          end else wk_q <= p_rdata;
        end
        // walk to the root of the second endpoint, then union and keep
        kst_pkg::StBldRb: begin
          if (root_hit) begin
            if ((wk_q != ra_q) && keep_ok) begin
              tcnt_q <= tcnt_q + VW'(1);
              sum_q  <= sum_q + TW'(ej_q[15:0]);
            end
            if (in_end) st_q <= kst_pkg::StEmitRd;
            else begin
              i_q  <= i_q + AW'(1);
              st_q <= kst_pkg::StBldRd;
            end
          end else wk_q <= p_rdata;
        end
        kst_pkg::StEmitRd: st_q <= kst_pkg::StEmit;
        kst_pkg::StEmit: if (out_if.ready) begin
          if (last_res) begin
            st_q   <= kst_pkg::StClear;
            cnt_q  <= '0;
            i_q    <= '0;
            tcnt_q <= '0;
            ocnt_q <= '0;
            sum_q  <= '0;
            drop_q <= 1'b0;
          end else begin
            ocnt_q <= ocnt_q + VW'(1);
            st_q   <= kst_pkg::StEmitRd;
          end
        end
        default: st_q <= kst_pkg::StIdle;
      endcase
    end
  end

  // result request
  assign out_if.valid        = (st_q == kst_pkg::StEmit);
  assign out_if.tree_valid   = has_tree;
  assign out_if.tree_from    = has_tree ? t_rdata[EW-1 -: VW] : '0;
  assign out_if.tree_to      = has_tree ? t_rdata[EW-1-VW -: VW] : '0;
  assign out_if.tree_weight  = has_tree ? t_rdata[15:0] : '0;
  assign out_if.total_weight = has_tree ? sum_q : '0;
  assign out_if.spanning     = (nv != '0) && ({1'b0, tcnt_q} == limit);
  assign out_if.dropped      = drop_q;
  assign out_if.last_result  = last_res;
endmodule

[hdl/kruskal_spanning_tree.sv]
// Sequence: after the last edge, an exchange sort of the stored edges (one compare per cycle),
// then per edge a read and a root walk of both endpoints, then a read and an offer per result.
// Throughput: one edge per cycle while loading; after the last edge, input stalls once the
// two-entry queue is full, until the results leave and the parent table clear is done.
// Reset: asynchronous active low clears run state and starts the parent table
// clear; num_vertices resets to 64.
// ----------------------------------------------------------------------------
// kruskal_spanning_tree: minimum spanning tree over loaded edges
// ----------------------------------------------------------------------------
module kruskal_spanning_tree #(
  parameter int unsigned MAX_EDGES   = 256,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  kst_in_if.sink     in_if,
  kst_out_if.source  out_if
);
  logic [6:0]         nv_q;
  logic               push, pop, fifo_full, fifo_empty;
  kst_pkg::edge_req_t push_data, pop_data;

  // vertex count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) nv_q <= 7'd64;
    else if (cfg_we_i) nv_q <= cfg_wdata_i;
  end

  kst_front u_front (
    .in_if       (in_if),
    .nv_i        (nv_q),
    .full_i      (fifo_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  kst_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (fifo_empty)
  );

  kst_back #(
    .MaxEdges (MAX_EDGES),
    .WBits    (WEIGHT_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .nv_i    (nv_q),
    .empty_i (fifo_empty),
    .req_i   (pop_data),
    .pop_o   (pop),
    .out_if  (out_if)
  );
endmodule

[hdl/kst_checker.sv]
// ----------------------------------------------------------------------------
// kst_checker: port-level checks for the spanning tree block
// ----------------------------------------------------------------------------
module kst_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid,
  input logic out_ready,
  input logic tree_valid,
  input logic last_result
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !tree_valid |-> last_result) else $error("empty result not last");
  a_last_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(last_result)) else $error("last moved");
endmodule

bind kruskal_spanning_tree kst_checker u_chk (
  .clk_i, .rst_ni, .out_valid(out_if.valid), .out_ready(out_if.ready),
  .tree_valid(out_if.tree_valid), .last_result(out_if.last_result)
);
